// ===== hdl/erq_pkg.sv =====
// Shared types and constants for the event interest and ready queue.
`timescale 1ns / 1ps
package erq_pkg;

   // Field widths of the request and response items
   localparam int OP_W     = 3;
   localparam int FD_W     = 8;
   localparam int EV_W     = 8;
   localparam int MAXEV_W  = 5;
   localparam int CNT_W    = 5;
   localparam int LIMIT_W  = 5;

   // Sizing defaults and fixed limits
   localparam int INTEREST_DEPTH_DEF = 16;
   localparam int READY_DEPTH_DEF    = 16;
   localparam int MAX_ITEMS          = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 3'd0,
      OP_MODIFY   = 3'd1,
      OP_DELETE   = 3'd2,
      OP_ACTIVATE = 3'd3,
      OP_WAIT     = 3'd4
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_EXEC,
      ST_RDWAIT,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;      // latch the accepted request
      logic lookup;       // search the interest table
      logic exec_single;  // apply the operation, load its single response
      logic wait_start;   // begin draining the ready list
      logic emit_entry;   // load one ready entry into the response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;     // response register can take a new item
      logic op_wait;      // latched request is a wait
      logic wait_drain;   // wait has entries to return
      logic last_entry;   // current drain entry is the final one
   } stat_type;

endpackage

// ===== hdl/erq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module erq_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/erq_ctrl.sv =====
// Sequencing state machine for the event interest and ready queue.
`timescale 1ns / 1ps
module erq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   output logic               req_ready,
   input  erq_pkg::stat_type  stat,
   output erq_pkg::cmd_type   cmd
);

   erq_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         erq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = erq_pkg::ST_FIND;
            end
         end
         erq_pkg::ST_FIND: begin
            cmd.lookup = 1'b1;
            state_in   = erq_pkg::ST_EXEC;
         end
         erq_pkg::ST_EXEC: begin
            if (stat.op_wait && stat.wait_drain) begin
               cmd.wait_start = 1'b1;
               state_in       = erq_pkg::ST_RDWAIT;
            end else if (stat.out_free) begin
               cmd.exec_single = 1'b1;
               state_in        = erq_pkg::ST_IDLE;
            end
         end
         erq_pkg::ST_RDWAIT: begin
            // ready list read in flight
            state_in = erq_pkg::ST_EMIT;
         end
         erq_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_entry = 1'b1;
               state_in       = stat.last_entry ? erq_pkg::ST_IDLE : erq_pkg::ST_RDWAIT;
            end
         end
         default: begin
            state_in = erq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/erq_dp.sv =====
// Datapath: interest table, ready list, counters and response register.
`timescale 1ns / 1ps
module erq_dp #(
   parameter int INTEREST_DEPTH = erq_pkg::INTEREST_DEPTH_DEF,
   parameter int READY_DEPTH    = erq_pkg::READY_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  erq_pkg::cmd_type              cmd,
   output erq_pkg::stat_type             stat,
   input  logic [erq_pkg::OP_W-1:0]      req_op,
   input  logic [erq_pkg::FD_W-1:0]      req_fd,
   input  logic [erq_pkg::EV_W-1:0]      req_mask,
   input  logic [erq_pkg::MAXEV_W-1:0]   req_maxev,
   input  logic                          csr_we,
   input  logic [erq_pkg::LIMIT_W-1:0]   csr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic                          rsp_entry_valid,
   output logic [erq_pkg::FD_W-1:0]      rsp_fd,
   output logic [erq_pkg::EV_W-1:0]      rsp_events,
   output logic [erq_pkg::CNT_W-1:0]     rsp_count,
   output logic                          rsp_last
);

   localparam int IA_W   = (INTEREST_DEPTH > 1) ? $clog2(INTEREST_DEPTH) : 1;
   localparam int RA_W   = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
   localparam int FILL_W = $clog2(READY_DEPTH + 1);
   localparam int NW     = (FILL_W > erq_pkg::CNT_W) ? FILL_W : erq_pkg::CNT_W;
   localparam int RD_W   = erq_pkg::FD_W + erq_pkg::EV_W;

   // Latched request
   logic [erq_pkg::OP_W-1:0]    op_ff;
   logic [erq_pkg::FD_W-1:0]    fd_ff;
   logic [erq_pkg::EV_W-1:0]    evm_ff;
   logic [erq_pkg::MAXEV_W-1:0] maxev_ff;

   // Interest table tags and lookup results
   logic [INTEREST_DEPTH-1:0]   ivalid_ff, ivalid_in;
   logic [erq_pkg::FD_W-1:0]    ifd_ff [INTEREST_DEPTH];
   logic [IA_W-1:0]             slot_ff, free_ff;
   logic                        hit_ff, any_free_ff;
   logic [INTEREST_DEPTH-1:0]   match_vec, free_vec;
   logic [IA_W-1:0]             enc_match, enc_free;

   // Ready list bookkeeping
   logic [erq_pkg::LIMIT_W-1:0] limit_ff;
   logic [FILL_W-1:0]           fill_ff, fill_in;
   logic [RA_W-1:0]             rd_idx_ff, rd_idx_in;
   logic [erq_pkg::CNT_W-1:0]   n_ff;
   logic [erq_pkg::CNT_W-1:0]   n_calc;
   logic                        act_ok;

   // Memory ports
   logic [erq_pkg::EV_W-1:0]    mask_q;
   logic                        mask_we;
   logic [IA_W-1:0]             mask_waddr, mask_raddr;
   logic                        rdy_we;
   logic [RD_W-1:0]             rdy_q;

   // Decoded operation
   logic is_add, is_mod, is_del, is_act, is_wait;

   // Response register
   logic                        out_valid_ff, out_valid_in;
   logic                        out_status_ff, out_status_in;
   logic                        out_ev_valid_ff, out_ev_valid_in;
   logic [erq_pkg::FD_W-1:0]    out_fd_ff, out_fd_in;
   logic [erq_pkg::EV_W-1:0]    out_ev_ff, out_ev_in;
   logic [erq_pkg::CNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_free;
   logic                        load_out;

   assign is_add  = (op_ff == erq_pkg::OP_ADD);
   assign is_mod  = (op_ff == erq_pkg::OP_MODIFY);
   assign is_del  = (op_ff == erq_pkg::OP_DELETE);
   assign is_act  = (op_ff == erq_pkg::OP_ACTIVATE);
   assign is_wait = (op_ff == erq_pkg::OP_WAIT);

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         fd_ff    <= req_fd;
         evm_ff   <= req_mask;
         maxev_ff <= req_maxev;
      end
   end

   // Parallel tag compare and lowest-index encode
   always_comb begin
      enc_match = '0;
      enc_free  = '0;
      for (int i = 0; i < INTEREST_DEPTH; i++) begin
         match_vec[i] = ivalid_ff[i] && (ifd_ff[i] == fd_ff);
         free_vec[i]  = !ivalid_ff[i];
      end
      for (int i = INTEREST_DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            enc_match = IA_W'(i);
         end
         if (free_vec[i]) begin
            enc_free = IA_W'(i);
         end
      end
   end

   // Lookup results
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         slot_ff     <= enc_match;
         free_ff     <= enc_free;
         hit_ff      <= |match_vec;
         any_free_ff <= |free_vec;
      end
   end

   // Mask store: read at the encoded slot during lookup, held after
   assign mask_raddr = cmd.lookup ? enc_match : slot_ff;
   assign mask_we    = cmd.exec_single && ((is_add && !hit_ff && any_free_ff) ||
                                           (is_mod && hit_ff));
   assign mask_waddr = is_add ? free_ff : slot_ff;

   erq_ram #(
      .WIDTH (erq_pkg::EV_W),
      .DEPTH (INTEREST_DEPTH)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (mask_waddr),
      .wr_data (evm_ff),
      .rd_addr (mask_raddr),
      .rd_data (mask_q)
   );

   // Activation admission and wait length
   always_comb begin
      logic [NW-1:0] fill_x;
      logic [NW-1:0] max_x;
      logic [NW-1:0] lim_x;
      logic [NW-1:0] nm;
      fill_x = NW'(fill_ff);
      max_x  = NW'(maxev_ff);
      lim_x  = NW'(limit_ff);
      act_ok = hit_ff && ((mask_q & evm_ff) != '0) && (fill_x < lim_x) &&
               (fill_ff < FILL_W'(READY_DEPTH));
      nm     = (fill_x < max_x) ? fill_x : max_x;
      nm     = (nm < NW'(erq_pkg::MAX_ITEMS)) ? nm : NW'(erq_pkg::MAX_ITEMS);
      n_calc = nm[erq_pkg::CNT_W-1:0];
   end

   // Ready list store: entry is {events, fd}
   assign rdy_we = cmd.exec_single && is_act && act_ok;

   erq_ram #(
      .WIDTH (RD_W),
      .DEPTH (READY_DEPTH)
   ) u_ready_ram (
      .clock   (clock),
      .wr_en   (rdy_we),
      .wr_addr (fill_ff[RA_W-1:0]),
      .wr_data ({evm_ff, fd_ff}),
      .rd_addr (rd_idx_ff),
      .rd_data (rdy_q)
   );

   // Table, fill and drain index updates
   always_comb begin
      ivalid_in = ivalid_ff;
      fill_in   = fill_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.exec_single) begin
         if (is_add && !hit_ff && any_free_ff) begin
            ivalid_in[free_ff] = 1'b1;
         end
         if (is_del && hit_ff) begin
            ivalid_in[slot_ff] = 1'b0;
         end
         if (rdy_we) begin
            fill_in = fill_ff + 1'b1;
         end
         // a valid wait with nothing to return still empties the list
         if (is_wait && (maxev_ff != '0)) begin
            fill_in = '0;
         end
      end
      if (cmd.wait_start) begin
         fill_in   = '0;
         rd_idx_in = '0;
      end
      if (cmd.emit_entry) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ivalid_ff <= '0;
         fill_ff   <= '0;
         limit_ff  <= erq_pkg::LIMIT_RESET;
      end else begin
         ivalid_ff <= ivalid_in;
         fill_ff   <= fill_in;
         if (csr_we) begin
            limit_ff <= csr_data;
         end
      end
   end

   // Descriptor tags of the table
   always_ff @(posedge clock) begin
      if (cmd.exec_single && is_add && !hit_ff && any_free_ff) begin
         ifd_ff[free_ff] <= fd_ff;
      end
   end

   // Drain index and wait length
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (cmd.wait_start) begin
         n_ff <= n_calc;
      end
   end

   // Response register next value
   assign out_free = !out_valid_ff || rsp_ready;
   assign load_out = cmd.exec_single || cmd.emit_entry;

   always_comb begin
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_status_in   = out_status_ff;
      out_ev_valid_in = out_ev_valid_ff;
      out_fd_in       = out_fd_ff;
      out_ev_in       = out_ev_ff;
      out_cnt_in      = out_cnt_ff;
      out_last_in     = out_last_ff;
      if (load_out) begin
         out_valid_in    = 1'b1;
         out_status_in   = 1'b0;
         out_ev_valid_in = 1'b0;
         out_fd_in       = '0;
         out_ev_in       = '0;
         out_cnt_in      = '0;
         out_last_in     = 1'b1;
         if (cmd.emit_entry) begin
            out_ev_valid_in = 1'b1;
            out_fd_in       = rdy_q[erq_pkg::FD_W-1:0];
            out_ev_in       = rdy_q[RD_W-1:erq_pkg::FD_W];
            out_cnt_in      = n_ff;
            out_last_in     = stat.last_entry;
         end else begin
            case (op_ff)
               erq_pkg::OP_ADD: begin
                  out_status_in = hit_ff || !any_free_ff;
               end
               erq_pkg::OP_MODIFY, erq_pkg::OP_DELETE: begin
                  out_status_in = !hit_ff;
               end
               erq_pkg::OP_ACTIVATE: begin
                  if (act_ok) begin
                     out_ev_valid_in = 1'b1;
                     out_fd_in       = fd_ff;
                     out_ev_in       = evm_ff;
                  end
               end
               erq_pkg::OP_WAIT: begin
                  out_status_in = (maxev_ff == '0);
               end
               default: begin
                  out_status_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff   <= out_status_in;
      out_ev_valid_ff <= out_ev_valid_in;
      out_fd_ff       <= out_fd_in;
      out_ev_ff       <= out_ev_in;
      out_cnt_ff      <= out_cnt_in;
      out_last_ff     <= out_last_in;
   end

   // Status to the controller
   always_comb begin
      stat.out_free   = out_free;
      stat.op_wait    = is_wait;
      stat.wait_drain = (maxev_ff != '0) && (n_calc != '0);
      stat.last_entry = ((NW'(rd_idx_ff) + NW'(1)) == NW'(n_ff));
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_entry_valid = out_ev_valid_ff;
   assign rsp_fd          = out_fd_ff;
   assign rsp_events      = out_ev_ff;
   assign rsp_count       = out_cnt_ff;
   assign rsp_last        = out_last_ff;

endmodule

// ===== hdl/event_interest_ready_queue.sv =====
// Top level of the event interest table and ready queue.
//
//   channel  direction  handshake              contents
//   req      in         req_tvalid/req_tready  tuser: operation; tdata: fd, mask, max
//   rsp      out        rsp_tvalid/rsp_tready  tuser: status, entry_valid; tdata; tlast
//   csr      in         csr_valid/csr_ready    ready_limit
//
// Add, modify, delete and activate pass through capture on accept, tag
// compare with mask read, then execute, which loads the response register.
// A wait that returns entries passes the same steps, then alternates a
// ready list read with the emit of each entry, paced by the single read
// port of the ready list. Synchronous active-high reset empties the interest
// table and ready list and sets the limit to 16. A stalled response holds the
// controller in its execute or emit state; a new request is taken once the
// last response of the previous one is in the output register.
`timescale 1ns / 1ps
module event_interest_ready_queue #(
   parameter int INTEREST_DEPTH = erq_pkg::INTEREST_DEPTH_DEF,
   parameter int READY_DEPTH    = erq_pkg::READY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] fd_in, [15:8] event_mask, [20:16] max_events
   input  logic [2:0]  req_tuser,   // [2:0] operation
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] fd_out, [15:8] events_out, [20:16] count
   output logic [1:0]  rsp_tuser,   // [0] status, [1] entry_valid
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_wdata    // ready_limit
);

   erq_pkg::cmd_type  cmd;
   erq_pkg::stat_type stat;

   logic                          req_fire;
   logic                          rsp_status;
   logic                          rsp_entry_valid;
   logic [erq_pkg::FD_W-1:0]      rsp_fd;
   logic [erq_pkg::EV_W-1:0]      rsp_events;
   logic [erq_pkg::CNT_W-1:0]     rsp_count;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   erq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   erq_dp #(
      .INTEREST_DEPTH (INTEREST_DEPTH),
      .READY_DEPTH    (READY_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_tuser),
      .req_fd          (req_tdata[7:0]),
      .req_mask        (req_tdata[15:8]),
      .req_maxev       (req_tdata[20:16]),
      .csr_we          (csr_valid && csr_ready),
      .csr_data        (csr_wdata),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_fd          (rsp_fd),
      .rsp_events      (rsp_events),
      .rsp_count       (rsp_count),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_count, rsp_events, rsp_fd};
   assign rsp_tuser = {rsp_entry_valid, rsp_status};

   // one request at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // an error response never carries a ready entry or a count
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1] && (rsp_tdata[20:16] == 5'd0))
      else $error("error response carries entry data");

   // a nonzero count only comes with a drained ready entry
   a_count_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[20:16] != 5'd0) |-> rsp_tuser[1])
      else $error("count set on a response without an entry");

   // responses without an entry are always single, final items
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tlast)
      else $error("non-entry response not marked last");

endmodule
